// ===== rtl/drtc_pkg.sv =====
// shared types, constants and calendar tables for the date-time string block
`default_nettype none
package drtc_pkg;

   localparam int unsigned STR_LEN  = 14;
   localparam int unsigned DATE_LEN = 8;

   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] ASCII_NINE = 8'h39;

   localparam logic [13:0] MIN_YEAR_RESET  = 14'd2020;
   localparam logic [13:0] MAX_YEAR_RESET  = 14'd2040;
   localparam logic [3:0]  MIN_MONTH_RESET = 4'd4;

   localparam logic [6:0] MAX_HOURS   = 7'd23;
   localparam logic [6:0] MAX_MINSEC  = 7'd59;
   localparam logic [6:0] MAX_DAY     = 7'd31;
   localparam logic [6:0] MAX_MONTH   = 7'd12;

   // register indexes of the csr port
   localparam logic [1:0] CSR_MIN_YEAR  = 2'd0;
   localparam logic [1:0] CSR_MAX_YEAR  = 2'd1;
   localparam logic [1:0] CSR_MIN_MONTH = 2'd2;

   typedef struct packed {
      logic [STR_LEN-1:0][3:0] digits;
      logic                    len_ok;
      logic                    date_nondigit;
      logic                    time_nondigit;
   } job_type;

   typedef struct packed {
      logic [13:0] min_year;
      logic [13:0] max_year;
      logic [3:0]  min_month;
   } cfg_type;

   typedef struct packed {
      logic [7:0] seconds;
      logic [7:0] minutes;
      logic [7:0] hours;
      logic [7:0] day;
      logic [7:0] month;
      logic [7:0] year;
   } bcd_type;

   typedef struct packed {
      logic       time_ok;
      logic       date_ok;
      logic [7:0] seconds_bcd;
      logic [7:0] minutes_bcd;
      logic [7:0] hours_bcd;
      logic [7:0] day_bcd;
      logic [2:0] day_of_week;
      logic [7:0] month_bcd;
      logic [7:0] year_bcd;
   } result_type;

   // two decimal digits to binary, 0..99
   function automatic logic [6:0] two_digits(input logic [3:0] hi, input logic [3:0] lo);
      return {hi, 3'b000} + {2'b00, hi, 1'b0} + {3'b000, lo};
   endfunction

   function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
      logic [4:0] len;
      unique case (m)
         4'd2:                      len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic [8:0] days_before(input logic leap, input logic [3:0] m);
      logic [8:0] base;
      unique case (m)
         4'd1:    base = 9'd0;
         4'd2:    base = 9'd31;
         4'd3:    base = 9'd59;
         4'd4:    base = 9'd90;
         4'd5:    base = 9'd120;
         4'd6:    base = 9'd151;
         4'd7:    base = 9'd181;
         4'd8:    base = 9'd212;
         4'd9:    base = 9'd243;
         4'd10:   base = 9'd273;
         4'd11:   base = 9'd304;
         4'd12:   base = 9'd334;
         default: base = 9'd0;
      endcase
      return base + ((leap && m > 4'd2) ? 9'd1 : 9'd0);
   endfunction

   // modulo 7 by octal digit folding, since 8 = 1 mod 7
   function automatic logic [2:0] mod7(input logic [13:0] a);
      logic [4:0] s1;
      logic [3:0] s2;
      s1 = {2'b00, a[2:0]} + {2'b00, a[5:3]} + {2'b00, a[8:6]} + {2'b00, a[11:9]}
           + {3'b000, a[13:12]};
      s2 = {1'b0, s1[2:0]} + {2'b00, s1[4:3]};
      return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/drtc_fifo.sv =====
// small register queue with count, used between the stages and at the output
`default_nettype none
module drtc_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_i,
   input  wire logic [WIDTH-1:0] wdata_i,
   input  wire logic             pop_i,
   output logic      [WIDTH-1:0] rdata_o,
   output logic                  full_o,
   output logic                  empty_o
);
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full_o  = (count_ff == CNT_W'(DEPTH));
   assign empty_o = (count_ff == '0);
   assign do_push = push_i && !full_o;
   assign do_pop  = pop_i && !empty_o;
   assign rdata_o = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata_i;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/drtc_front.sv =====
// front end: collects characters into digit nibbles and emits one job per string
`default_nettype none
module drtc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept_i,
   input  wire logic [7:0]        char_code_i,
   input  wire logic              final_char_i,
   output drtc_pkg::job_type      job_o,
   output logic                   job_push_o
);
   import drtc_pkg::*;

   logic [3:0]              pos_ff, pos_in;
   logic [STR_LEN-1:0][3:0] digit_ff, digit_in;
   logic                    date_nd_ff, date_nd_in;
   logic                    time_nd_ff, time_nd_in;
   logic                    is_digit;
   logic [3:0]              nibble;
   logic                    in_string;

   assign is_digit  = (char_code_i >= ASCII_ZERO) && (char_code_i <= ASCII_NINE);
   assign nibble    = is_digit ? char_code_i[3:0] : 4'd0;
   assign in_string = (pos_ff < 4'(STR_LEN));

   always_comb begin
      digit_in   = digit_ff;
      date_nd_in = date_nd_ff;
      time_nd_in = time_nd_ff;
      pos_in     = (pos_ff == 4'hF) ? pos_ff : pos_ff + 4'd1;
      for (int i = 0; i < STR_LEN; i++) begin
         if (pos_ff == 4'(i)) begin
            digit_in[i] = nibble;
         end
      end
      if (in_string && !is_digit) begin
         if (pos_ff < 4'(DATE_LEN)) begin
            date_nd_in = 1'b1;
         end else begin
            time_nd_in = 1'b1;
         end
      end
   end

   // job reflects the string including the last character
   assign job_o.digits        = digit_in;
   assign job_o.len_ok        = (pos_in == 4'(STR_LEN));
   assign job_o.date_nondigit = date_nd_in;
   assign job_o.time_nondigit = time_nd_in;
   assign job_push_o          = accept_i && final_char_i;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         digit_ff   <= '0;
         date_nd_ff <= 1'b0;
         time_nd_ff <= 1'b0;
      end else if (accept_i) begin
         if (final_char_i) begin
            pos_ff     <= '0;
            digit_ff   <= '0;
            date_nd_ff <= 1'b0;
            time_nd_ff <= 1'b0;
         end else begin
            pos_ff     <= pos_in;
            digit_ff   <= digit_in;
            date_nd_ff <= date_nd_in;
            time_nd_ff <= time_nd_in;
         end
      end
   end

endmodule
`default_nettype wire

// ===== rtl/drtc_back.sv =====
// back end: four stage pipeline for range checks, bcd bytes and weekday
`default_nettype none
module drtc_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire drtc_pkg::job_type    job_i,
   input  wire logic                 job_empty_i,
   output logic                      job_pop_o,
   input  wire drtc_pkg::cfg_type    cfg_i,
   output drtc_pkg::result_type      res_o,
   output logic                      res_push_o,
   input  wire logic                 res_full_i
);
   import drtc_pkg::*;

   logic adv;
   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;

   // stage a
   logic [6:0] a_hi_ff, a_lo_ff, a_day_ff, a_mon_ff, a_hrs_ff, a_min_ff, a_sec_ff;
   logic       a_time_pre_ff, a_date_pre_ff;
   bcd_type    a_bcd_ff, a_bcd_in;

   // stage b
   logic [13:0] b_year_ff, b_year_in;
   logic [11:0] b_leaps_ff, b_leaps_in;
   logic        b_leap_ff, b_leap_in;
   logic [3:0]  b_mon_c_ff, b_mon_c_in;
   logic [6:0]  b_day_ff, b_mon_ff;
   logic        b_time_ok_ff, b_time_ok_in;
   logic        b_date_pre_ff, b_date_pre_in;
   bcd_type     b_bcd_ff;

   // stage c
   logic        c_time_ok_ff;
   logic        c_date_ok_ff, c_date_ok_in;
   logic [8:0]  c_yd_ff, c_yd_in;
   logic [13:0] c_sy_ff, c_sy_in;
   bcd_type     c_bcd_ff;
   logic [4:0]  c_ml;
   logic [6:0]  c_day_c;

   // stage d
   result_type  d_res_ff, d_res_in;
   logic [13:0] d_total;

   assign adv        = !d_valid_ff || !res_full_i;
   assign job_pop_o  = adv && !job_empty_i;
   assign res_push_o = d_valid_ff && !res_full_i;
   assign res_o      = d_res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= !job_empty_i;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   // stage a: digit pairs
   assign a_bcd_in.seconds = {job_i.digits[12], job_i.digits[13]};
   assign a_bcd_in.minutes = {job_i.digits[10], job_i.digits[11]};
   assign a_bcd_in.hours   = {job_i.digits[8],  job_i.digits[9]};
   assign a_bcd_in.day     = {job_i.digits[0],  job_i.digits[1]};
   assign a_bcd_in.month   = {job_i.digits[2],  job_i.digits[3]};
   assign a_bcd_in.year    = {job_i.digits[6],  job_i.digits[7]};

   always_ff @(posedge clock) begin
      if (adv) begin
         a_hi_ff       <= two_digits(job_i.digits[4],  job_i.digits[5]);
         a_lo_ff       <= two_digits(job_i.digits[6],  job_i.digits[7]);
         a_day_ff      <= two_digits(job_i.digits[0],  job_i.digits[1]);
         a_mon_ff      <= two_digits(job_i.digits[2],  job_i.digits[3]);
         a_hrs_ff      <= two_digits(job_i.digits[8],  job_i.digits[9]);
         a_min_ff      <= two_digits(job_i.digits[10], job_i.digits[11]);
         a_sec_ff      <= two_digits(job_i.digits[12], job_i.digits[13]);
         a_time_pre_ff <= job_i.len_ok && !job_i.time_nondigit;
         a_date_pre_ff <= job_i.len_ok && !job_i.date_nondigit;
         a_bcd_ff      <= a_bcd_in;
      end
   end

   // stage b: year, leap count before this year, clamped month, time check
   always_comb begin
      b_year_in = 14'(a_hi_ff) * 14'd100 + 14'(a_lo_ff);
      if (a_lo_ff != 7'd0) begin
         b_leaps_in = 12'(a_hi_ff) * 12'd24 + 12'(a_lo_ff - 7'd1) / 12'd4
                      + 12'(a_hi_ff) / 12'd4;
      end else if (a_hi_ff != 7'd0) begin
         b_leaps_in = 12'(a_hi_ff) * 12'd24 + 12'(a_hi_ff - 7'd1) / 12'd4;
      end else begin
         b_leaps_in = '0;
      end
      // year zero counts as common
      if (a_lo_ff != 7'd0) begin
         b_leap_in = (a_lo_ff[1:0] == 2'b00);
      end else begin
         b_leap_in = (a_hi_ff != 7'd0) && (a_hi_ff[1:0] == 2'b00);
      end
      if (a_mon_ff == 7'd0) begin
         b_mon_c_in = 4'd1;
      end else if (a_mon_ff > MAX_MONTH) begin
         b_mon_c_in = 4'd12;
      end else begin
         b_mon_c_in = a_mon_ff[3:0];
      end
      b_time_ok_in  = a_time_pre_ff && (a_hrs_ff <= MAX_HOURS)
                      && (a_min_ff <= MAX_MINSEC) && (a_sec_ff <= MAX_MINSEC);
      b_date_pre_in = a_date_pre_ff && (a_day_ff != 7'd0) && (a_day_ff <= MAX_DAY)
                      && (a_mon_ff != 7'd0) && (a_mon_ff <= MAX_MONTH);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_year_ff     <= b_year_in;
         b_leaps_ff    <= b_leaps_in;
         b_leap_ff     <= b_leap_in;
         b_mon_c_ff    <= b_mon_c_in;
         b_day_ff      <= a_day_ff;
         b_mon_ff      <= a_mon_ff;
         b_time_ok_ff  <= b_time_ok_in;
         b_date_pre_ff <= b_date_pre_in;
         b_bcd_ff      <= a_bcd_ff;
      end
   end

   // stage c: year window, day of year, year contribution
   always_comb begin
      c_ml = month_len(b_leap_ff, b_mon_c_ff);
      if (b_day_ff == 7'd0) begin
         c_day_c = 7'd1;
      end else if (b_day_ff > 7'(c_ml)) begin
         c_day_c = 7'(c_ml);
      end else begin
         c_day_c = b_day_ff;
      end
      c_yd_in      = days_before(b_leap_ff, b_mon_c_ff) + 9'(c_day_c) - 9'd1;
      c_sy_in      = b_year_ff + 14'(b_leaps_ff);
      c_date_ok_in = b_date_pre_ff && (b_year_ff >= cfg_i.min_year)
                     && (b_year_ff <= cfg_i.max_year)
                     && !((b_year_ff == cfg_i.min_year)
                          && (b_mon_ff < 7'(cfg_i.min_month)));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_time_ok_ff <= b_time_ok_ff;
         c_date_ok_ff <= c_date_ok_in;
         c_yd_ff      <= c_yd_in;
         c_sy_ff      <= c_sy_in;
         c_bcd_ff     <= b_bcd_ff;
      end
   end

   // stage d: weekday, since 365 = 1 mod 7 the year term is year plus leaps
   assign d_total = c_sy_ff + 14'(c_yd_ff);

   always_comb begin
      d_res_in.time_ok     = c_time_ok_ff;
      d_res_in.date_ok     = c_date_ok_ff;
      d_res_in.seconds_bcd = c_bcd_ff.seconds;
      d_res_in.minutes_bcd = c_bcd_ff.minutes;
      d_res_in.hours_bcd   = c_bcd_ff.hours;
      d_res_in.day_bcd     = c_bcd_ff.day;
      d_res_in.day_of_week = mod7(d_total);
      d_res_in.month_bcd   = c_bcd_ff.month;
      d_res_in.year_bcd    = c_bcd_ff.year;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_res_ff <= d_res_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/datetime_string_to_rtc_registers_core.sv =====
// top level: ascii date-time string to bcd rtc register bytes with weekday
`default_nettype none
// throughput: one character per cycle while full is low, and one string per cycle when strings end back to back
// a result reaches the rsp ports once the beat carrying the last character has passed through
//   the job queue, four back-end pipeline stages and the result queue
// back end stalls only while the result queue is full; full rises once the job queue fills
// reset (synchronous) clears the character count, digits, flags, queues and pipeline valids,
//   and loads the year window registers with their defaults; no clearing pass
module datetime_string_to_rtc_registers_core #(
   parameter int unsigned JOB_DEPTH = 2,
   parameter int unsigned RSP_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // character beats
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_char_code,
   input  wire logic        req_final_char,
   // result beats
   output logic             empty,
   input  wire logic        pop,
   output logic             rsp_time_ok,
   output logic             rsp_date_ok,
   output logic [7:0]       rsp_seconds_bcd,
   output logic [7:0]       rsp_minutes_bcd,
   output logic [7:0]       rsp_hours_bcd,
   output logic [7:0]       rsp_day_bcd,
   output logic [2:0]       rsp_day_of_week,
   output logic [7:0]       rsp_month_bcd,
   output logic [7:0]       rsp_year_bcd,
   // register writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [13:0] csr_wdata
);
   import drtc_pkg::*;

   localparam int unsigned JOB_W = $bits(job_type);
   localparam int unsigned RES_W = $bits(result_type);

   // config registers
   logic [13:0] min_year_ff;
   logic [13:0] max_year_ff;
   logic [3:0]  min_month_ff;
   cfg_type     cfg;

   // front to job queue
   logic        accept;
   job_type     front_job;
   logic        front_push;

   // job queue to back end
   logic [JOB_W-1:0] job_rdata;
   job_type          back_job;
   logic             job_empty;
   logic             job_pop;

   // back end to result queue
   result_type       back_res;
   logic             back_push;
   logic             rsp_full;
   logic [RES_W-1:0] rsp_rdata;
   result_type       rsp;

   // csr port always takes a write; the user must write only while idle, the block does not enforce it
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_year_ff  <= MIN_YEAR_RESET;
         max_year_ff  <= MAX_YEAR_RESET;
         min_month_ff <= MIN_MONTH_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MIN_YEAR:  min_year_ff  <= csr_wdata;
            CSR_MAX_YEAR:  max_year_ff  <= csr_wdata;
            CSR_MIN_MONTH: min_month_ff <= csr_wdata[3:0];
            default:       ;   // index beyond the register list is dropped
         endcase
      end
   end

   assign cfg.min_year  = min_year_ff;
   assign cfg.max_year  = max_year_ff;
   assign cfg.min_month = min_month_ff;

   // front end: one character per beat, job pushed on the last character
   assign accept = push && !full;

   drtc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept_i     (accept),
      .char_code_i  (req_char_code),
      .final_char_i (req_final_char),
      .job_o        (front_job),
      .job_push_o   (front_push)
   );

   // job queue decouples the front from the back end pipeline
   drtc_fifo #(
      .WIDTH (JOB_W),
      .DEPTH (JOB_DEPTH)
   ) u_job_q (
      .clock   (clock),
      .reset   (reset),
      .push_i  (front_push),
      .wdata_i (front_job),
      .pop_i   (job_pop),
      .rdata_o (job_rdata),
      .full_o  (full),
      .empty_o (job_empty)
   );

   assign back_job = job_type'(job_rdata);

   // back end: checks, bcd bytes, weekday
   drtc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_i       (back_job),
      .job_empty_i (job_empty),
      .job_pop_o   (job_pop),
      .cfg_i       (cfg),
      .res_o       (back_res),
      .res_push_o  (back_push),
      .res_full_i  (rsp_full)
   );

   // result queue acts as the output register stage
   drtc_fifo #(
      .WIDTH (RES_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push_i  (back_push),
      .wdata_i (back_res),
      .pop_i   (pop),
      .rdata_o (rsp_rdata),
      .full_o  (rsp_full),
      .empty_o (empty)
   );

   assign rsp             = result_type'(rsp_rdata);
   assign rsp_time_ok     = rsp.time_ok;
   assign rsp_date_ok     = rsp.date_ok;
   assign rsp_seconds_bcd = rsp.seconds_bcd;
   assign rsp_minutes_bcd = rsp.minutes_bcd;
   assign rsp_hours_bcd   = rsp.hours_bcd;
   assign rsp_day_bcd     = rsp.day_bcd;
   assign rsp_day_of_week = rsp.day_of_week;
   assign rsp_month_bcd   = rsp.month_bcd;
   assign rsp_year_bcd    = rsp.year_bcd;

   // the last character of a string leaves a job waiting for the back end
   a_final_makes_job: assert property (@(posedge clock) disable iff (reset)
      (push && !full && req_final_char) |=> !job_empty)
      else $error("last character did not queue a job");

   // weekday folding never yields seven
   a_weekday_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_day_of_week != 3'd7))
      else $error("weekday out of range");

   // a valid time has an hours tens digit of at most two
   a_time_ok_hours: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_time_ok) |-> (rsp_hours_bcd[7:4] <= 4'd2))
      else $error("time flagged valid with bad hours");

   // a valid date never has month zero
   a_date_ok_month: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_date_ok) |-> (rsp_month_bcd != 8'h00))
      else $error("date flagged valid with month zero");

endmodule
`default_nettype wire

// ===== tb/tb_datetime_string_to_rtc_registers_core.sv =====
// testbench for the date-time string to rtc register block: predictor, drivers and regression
module tb_datetime_string_to_rtc_registers_core;
   timeunit 1ns;
   timeprecision 1ps;

   import drtc_pkg::*;

   // the csr index port is two bits wide; the top code maps to no register
   localparam logic [1:0] CSR_SPARE = 2'd3;

   localparam int SETTLE_CYCLES = 12;    // time for a result to pass the queues and pipeline, plus margin
   localparam int STALL_LIMIT   = 4000;  // cycles with no beat on any port before giving up
   localparam int IDLE_PCT      = 12;

   typedef logic [7:0] beat_q_type[$];

   // keeps its own copy of the year window, the digit store and the flags, and predicts
   // the register bytes that each final char should produce
   class rtc_bytes_tracker;
      logic [13:0] min_year;
      logic [13:0] max_year;
      logic [3:0]  min_month;
      logic [3:0]  char_count;
      logic [3:0]  digit [STR_LEN];
      bit          date_bad;
      bit          time_bad;
      result_type  awaited_regs[$];
      int          faults;

      function new();
         min_year  = MIN_YEAR_RESET;
         max_year  = MAX_YEAR_RESET;
         min_month = MIN_MONTH_RESET;
         faults    = 0;
         restart();
      endfunction

      function void restart();
         char_count = '0;
         foreach (digit[i]) digit[i] = '0;
         date_bad = 1'b0;
         time_bad = 1'b0;
      endfunction

      function void write_reg(logic [1:0] index, logic [13:0] value);
         case (index)
            CSR_MIN_YEAR:  min_year  = value;
            CSR_MAX_YEAR:  max_year  = value;
            CSR_MIN_MONTH: min_month = value[3:0];
            default: ;
         endcase
      endfunction

      function int unsigned month_days(bit leap, int unsigned m);
         int unsigned n;
         case (m)
            2:           n = leap ? 29 : 28;
            4, 6, 9, 11: n = 30;
            default:     n = 31;
         endcase
         return n;
      endfunction

      // weekday with month and day clamped first; year 0 is common and starts on a sunday
      function logic [2:0] weekday(int unsigned y, int unsigned m, int unsigned d);
         bit          leap;
         int unsigned yday;
         int unsigned leaps;
         leap = y > 0 && y % 4 == 0 && (y % 100 != 0 || y % 400 == 0);
         if (m < 1) m = 1;
         if (m > 12) m = 12;
         if (d < 1) d = 1;
         if (d > month_days(leap, m)) d = month_days(leap, m);
         yday = d - 1;
         for (int k = 1; k < m; k++) yday += month_days(leap, k);
         leaps = (y > 0) ? (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400 : 0;
         return 3'(((y * 365 + leaps) % 7 + yday) % 7);
      endfunction

      function int unsigned pair_value(int p);
         return digit[p] * 10 + digit[p + 1];
      endfunction

      function void take_char(logic [7:0] code, logic last);
         bit          is_digit;
         bit          len_ok;
         int unsigned day, mon, yr, hrs, mins, secs;
         result_type  r;
         is_digit = code >= ASCII_ZERO && code <= ASCII_NINE;
         if (char_count < STR_LEN) begin
            digit[char_count] = is_digit ? 4'(code - ASCII_ZERO) : 4'd0;
            if (!is_digit) begin
               if (char_count < DATE_LEN) date_bad = 1'b1;
               else time_bad = 1'b1;
            end
         end
         if (char_count != 4'd15) char_count++;
         if (!last) return;

         len_ok = char_count == STR_LEN;
         day  = pair_value(0);
         mon  = pair_value(2);
         yr   = pair_value(4) * 100 + pair_value(6);
         hrs  = pair_value(8);
         mins = pair_value(10);
         secs = pair_value(12);

         r.time_ok = len_ok && !time_bad && hrs <= MAX_HOURS && mins <= MAX_MINSEC
                     && secs <= MAX_MINSEC;
         r.date_ok = len_ok && !date_bad && day >= 1 && day <= MAX_DAY && mon >= 1
                     && mon <= MAX_MONTH && yr >= min_year && yr <= max_year
                     && !(yr == min_year && mon < min_month);
         r.seconds_bcd = {digit[12], digit[13]};
         r.minutes_bcd = {digit[10], digit[11]};
         r.hours_bcd   = {digit[8], digit[9]};
         r.day_bcd     = {digit[0], digit[1]};
         r.day_of_week = weekday(yr, mon, day);
         r.month_bcd   = {digit[2], digit[3]};
         r.year_bcd    = {digit[6], digit[7]};
         awaited_regs.push_back(r);
         restart();
      endfunction

      function void compare(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            faults++;
         end
      endfunction

      function void check_regs(result_type got);
         result_type want;
         if (awaited_regs.size() == 0) begin
            $error("result beat with no result awaited");
            faults++;
            return;
         end
         want = awaited_regs.pop_front();
         compare("time_ok",     want.time_ok,     got.time_ok);
         compare("date_ok",     want.date_ok,     got.date_ok);
         compare("seconds_bcd", want.seconds_bcd, got.seconds_bcd);
         compare("minutes_bcd", want.minutes_bcd, got.minutes_bcd);
         compare("hours_bcd",   want.hours_bcd,   got.hours_bcd);
         compare("day_bcd",     want.day_bcd,     got.day_bcd);
         compare("day_of_week", want.day_of_week, got.day_of_week);
         compare("month_bcd",   want.month_bcd,   got.month_bcd);
         compare("year_bcd",    want.year_bcd,    got.year_bcd);
      endfunction
   endclass

   logic        clock;
   logic        reset          = 1'b1;
   logic        push           = 1'b0;
   logic        full;
   logic [7:0]  req_char_code  = '0;
   logic        req_final_char = 1'b0;
   logic        empty;
   logic        pop            = 1'b0;
   logic        rsp_time_ok;
   logic        rsp_date_ok;
   logic [7:0]  rsp_seconds_bcd;
   logic [7:0]  rsp_minutes_bcd;
   logic [7:0]  rsp_hours_bcd;
   logic [7:0]  rsp_day_bcd;
   logic [2:0]  rsp_day_of_week;
   logic [7:0]  rsp_month_bcd;
   logic [7:0]  rsp_year_bcd;
   logic        csr_valid      = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index      = CSR_MIN_YEAR;
   logic [13:0] csr_wdata      = '0;

   bit               no_idle     = 1'b0;   // set for the stretch where neither side backs off
   int               stall_count = 0;
   rtc_bytes_tracker tracker     = new();

   datetime_string_to_rtc_registers_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_char_code   (req_char_code),
      .req_final_char  (req_final_char),
      .empty           (empty),
      .pop             (pop),
      .rsp_time_ok     (rsp_time_ok),
      .rsp_date_ok     (rsp_date_ok),
      .rsp_seconds_bcd (rsp_seconds_bcd),
      .rsp_minutes_bcd (rsp_minutes_bcd),
      .rsp_hours_bcd   (rsp_hours_bcd),
      .rsp_day_bcd     (rsp_day_bcd),
      .rsp_day_of_week (rsp_day_of_week),
      .rsp_month_bcd   (rsp_month_bcd),
      .rsp_year_bcd    (rsp_year_bcd),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic bit take_break();
      return !no_idle && $urandom_range(0, 99) < IDLE_PCT;
   endfunction

   // one char beat: drive at the falling edge, see it taken at the rising edge
   task automatic send_char(logic [7:0] code, logic last);
      do begin
         @(negedge clock);
         if (take_break()) begin
            push <= 1'b0;
         end else begin
            push           <= 1'b1;
            req_char_code  <= code;
            req_final_char <= last;
         end
         @(posedge clock);
      end while (!(push && !full));
      tracker.take_char(code, last);
   endtask

   // a whole string; only its last char carries the final flag
   task automatic send_beats(beat_q_type q);
      foreach (q[i]) send_char(q[i], i == q.size() - 1);
   endtask

   // csr_valid stays up across back-to-back writes and is lowered by the caller
   task automatic csr_write(logic [1:0] index, logic [13:0] value);
      do begin
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_index <= index;
         csr_wdata <= value;
         @(posedge clock);
      end while (!csr_ready);
      tracker.write_reg(index, value);
   endtask

   // drain every awaited result, then give the pipeline time to empty
   task automatic settle();
      @(negedge clock);
      push      <= 1'b0;
      csr_valid <= 1'b0;
      while (tracker.awaited_regs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // new year window, written only once the block has gone quiet
   task automatic set_window(logic [13:0] lo, logic [13:0] hi, logic [13:0] month_word,
                             bit poke_spare);
      settle();
      csr_write(CSR_MIN_YEAR, lo);
      csr_write(CSR_MAX_YEAR, hi);
      csr_write(CSR_MIN_MONTH, month_word);
      if (poke_spare) csr_write(CSR_SPARE, 14'h2AAA);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic beat_q_type text_beats(string s);
      beat_q_type q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   // mostly a legal value, now and then any value up to wide_max
   function automatic int unsigned near_range(int unsigned legal_max, int unsigned wide_max);
      return ($urandom_range(0, 7) == 0) ? $urandom_range(0, wide_max)
                                         : $urandom_range(0, legal_max);
   endfunction

   // years clustered on the edges of the current window
   function automatic int unsigned pick_year();
      int unsigned lo;
      int unsigned hi;
      int unsigned y;
      lo = tracker.min_year;
      hi = tracker.max_year;
      case ($urandom_range(0, 7))
         0:       y = lo;
         1:       y = hi;
         2:       y = (lo > 0) ? lo - 1 : 0;
         3:       y = hi + 1;
         4:       y = $urandom_range(0, 9999);
         default: y = $urandom_range(lo, hi);
      endcase
      return (y > 9999) ? 9999 : y;
   endfunction

   function automatic beat_q_type random_string();
      beat_q_type  q;
      int unsigned kind;
      int unsigned day;
      int          mon;
      kind = $urandom_range(0, 99);
      // pure noise of random length
      if (kind >= 88) begin
         repeat ($urandom_range(1, 18)) q.push_back(8'($urandom_range(0, 255)));
         return q;
      end
      if (kind >= 64 && kind < 70) begin
         // any digit at any place
         repeat (STR_LEN) q.push_back(8'(ASCII_ZERO + $urandom_range(0, 9)));
      end else begin
         if ($urandom_range(0, 9) == 0) mon = $urandom_range(0, 19);
         else if ($urandom_range(0, 3) == 0) mon = int'(tracker.min_month) + $urandom_range(0, 2) - 1;
         else mon = $urandom_range(1, 12);
         if (mon < 0) mon = 0;
         if ($urandom_range(0, 9) == 0) day = $urandom_range(0, 39);
         else if ($urandom_range(0, 4) == 0) day = $urandom_range(28, 31);
         else day = $urandom_range(1, 31);
         q = text_beats($sformatf("%02d%02d%04d%02d%02d%02d", day, mon, pick_year(),
                                  near_range(23, 29), near_range(59, 69), near_range(59, 69)));
      end
      if (kind >= 70 && kind < 80) begin
         // one char swapped for an arbitrary byte
         q[$urandom_range(0, STR_LEN - 1)] = 8'($urandom_range(0, 255));
      end else if (kind >= 80) begin
         // cut short or run long
         if ($urandom_range(0, 1)) begin
            repeat ($urandom_range(1, STR_LEN - 1)) void'(q.pop_back());
         end else begin
            repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
         end
      end
      return q;
   endfunction

   task automatic run_random(int strings);
      repeat (strings) send_beats(random_string());
   endtask

   // result side: pop mostly high, dropped now and then
   initial begin
      forever begin
         @(negedge clock);
         pop <= !take_break();
      end
   end

   // every popped beat is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         tracker.check_regs({rsp_time_ok, rsp_date_ok, rsp_seconds_bcd, rsp_minutes_bcd,
                             rsp_hours_bcd, rsp_day_bcd, rsp_day_of_week, rsp_month_bcd,
                             rsp_year_bcd});
      end
   end

   // watchdog: too long without a beat on any port means the block is stuck
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready)) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
      end
      if (stall_count >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      beat_q_type odd;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed strings under the reset window
      // all zero: year 0, day and month 0 clamped for the weekday
      send_beats(text_beats("00000000000000"));
      // non-digits in both halves, bytes just outside the digit range, all bits set and clear
      odd = text_beats("99999999959595");
      odd[0]  = 8'hFF;
      odd[8]  = 8'h00;
      odd[9]  = 8'h2F;
      odd[10] = 8'h3A;
      odd[13] = 8'h80;
      send_beats(odd);
      // feb 31 in a leap year, clamped to the 29th, top of the time ranges
      send_beats(text_beats("31022024235959"));
      // single char string
      send_beats(text_beats("7"));
      // sixteen chars: count saturates, both flags drop
      send_beats(text_beats("0101203012000000"));
      run_random(10);

      // widest legal window
      set_window(14'd0, 14'd9999, 14'd1, 1'b0);
      run_random(14);

      // narrow window, last month as the floor, no idling on either side
      no_idle = 1'b1;
      set_window(14'd1999, 14'd2001, 14'd12, 1'b0);
      run_random(14);
      no_idle = 1'b0;

      // top of the register range; month word only keeps its low nibble (0 here)
      set_window(14'd9999, 14'h3FFF, 14'h3FF0, 1'b0);
      run_random(12);

      // inverted window, nothing can be a valid date
      set_window(14'd2040, 14'd2020, 14'd15, 1'b0);
      run_random(12);

      // century window around 2000 and 2100, plus a write to the unused index
      set_window(14'd2000, 14'd2100, 14'd2, 1'b1);
      run_random(14);

      settle();
      if (tracker.faults == 0 && tracker.awaited_regs.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
